// ===== rtl/crd_pkg.sv =====
// shared types, codes and header layout tables for the consensus rpc deframer
`timescale 1ns / 1ps
`default_nettype none
package crd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_OP_SET    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OP_DELETE = 1'd1;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_ENTRY  = 3'd1;
    localparam logic [2:0] KIND_KEY    = 3'd2;
    localparam logic [2:0] KIND_VALUE  = 3'd3;
    localparam logic [2:0] KIND_STATUS = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_TRAILING  = 2'd2;
    localparam logic [1:0] ST_BAD_OP    = 2'd3;

    localparam logic [1:0] MSG_VOTE_REQ     = 2'd0;
    localparam logic [1:0] MSG_VOTE_REPLY   = 2'd1;
    localparam logic [1:0] MSG_APPEND_REQ   = 2'd2;
    localparam logic [1:0] MSG_APPEND_REPLY = 2'd3;

    localparam logic [2:0] EF_TERM  = 3'd0;
    localparam logic [2:0] EF_INDEX = 3'd1;
    localparam logic [2:0] EF_OP    = 3'd2;
    localparam logic [2:0] EF_KLEN  = 3'd3;
    localparam logic [2:0] EF_VLEN  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic [1:0] req_type;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [2:0]  field_index;
        logic [63:0] field_value;
        logic [31:0] entry_number;
        logic [1:0]  status;
        logic        last;
    } result_t;

    // one parsed item: an optional field or byte beat, then an optional status beat
    typedef struct packed {
        logic       has_res;
        result_t    res;
        logic       has_status;
        logic [1:0] status;
    } rec_t;

    function automatic logic [3:0] hdr_width(input logic [1:0] kind, input logic [2:0] idx);
        logic [3:0] w;
        begin
            w = 4'd0;
            case (kind)
                MSG_VOTE_REQ:
                begin
                    case (idx)
                        3'd0: w = 4'd8;
                        3'd1: w = 4'd4;
                        3'd2: w = 4'd8;
                        3'd3: w = 4'd8;
                        default: w = 4'd0;
                    endcase
                end
                MSG_APPEND_REQ:
                begin
                    case (idx)
                        3'd0: w = 4'd8;
                        3'd1: w = 4'd4;
                        3'd2: w = 4'd8;
                        3'd3: w = 4'd8;
                        3'd4: w = 4'd8;
                        3'd5: w = 4'd4;
                        default: w = 4'd0;
                    endcase
                end
                default:
                begin
                    case (idx)
                        3'd0: w = 4'd8;
                        3'd1: w = 4'd1;
                        default: w = 4'd0;
                    endcase
                end
            endcase
            return w;
        end
    endfunction

    function automatic logic [2:0] hdr_count(input logic [1:0] kind);
        logic [2:0] c;
        begin
            case (kind)
                MSG_VOTE_REQ:   c = 3'd4;
                MSG_APPEND_REQ: c = 3'd6;
                default:        c = 3'd2;
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/crd_front.sv =====
// byte parser: assembles fields, tracks entries and errors, builds at most one record per item
`timescale 1ns / 1ps
`default_nettype none
module crd_front #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         take,
    input  wire crd_pkg::item_t               item,
    input  wire logic                         cfg_we,
    input  wire logic [crd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                   cfg_data,
    output logic                              push,
    output crd_pkg::rec_t                     rec
);

    localparam logic [3:0] PH_HDR0    = 4'd0;
    localparam logic [3:0] PH_E_TERM  = 4'd6;
    localparam logic [3:0] PH_E_INDEX = 4'd7;
    localparam logic [3:0] PH_E_OP    = 4'd8;
    localparam logic [3:0] PH_E_KLEN  = 4'd9;
    localparam logic [3:0] PH_E_KEY   = 4'd10;
    localparam logic [3:0] PH_E_VLEN  = 4'd11;
    localparam logic [3:0] PH_E_VAL   = 4'd12;
    localparam logic [3:0] PH_DONE    = 4'd13;
    localparam logic [3:0] PH_ERROR   = 4'd14;

    logic [7:0]             op_set_reg;
    logic [7:0]             op_del_reg;
    logic [3:0]             phase_reg, phase_next;
    logic [2:0]             bif_reg, bif_next;
    logic [63:0]            shift_reg, shift_next;
    logic [31:0]            entries_reg, entries_next;
    logic [31:0]            entry_cnt_reg, entry_cnt_next;
    logic [LENGTH_BITS-1:0] payload_reg, payload_next;
    logic [1:0]             err_reg, err_next;
    logic [1:0]             kind_reg, kind_next;
    logic                   in_msg_reg, in_msg_next;

    logic        active;
    logic [1:0]  eff_kind;
    logic [3:0]  width;
    logic [63:0] shift_cat;
    logic [63:0] v;
    logic        do_fail;
    logic [1:0]  fail_code;
    logic        entry_end;

    assign active = take && (item.has_byte || item.end_of_message);
    assign eff_kind = in_msg_reg ? kind_reg : item.req_type;
    assign shift_cat = {shift_reg[55:0], item.data_byte};

    always_comb
    begin
        if (phase_reg < PH_E_TERM)
            width = crd_pkg::hdr_width(eff_kind, phase_reg[2:0]);
        else if (phase_reg == PH_E_OP)
            width = 4'd1;
        else if (phase_reg == PH_E_KLEN || phase_reg == PH_E_VLEN)
            width = 4'd4;
        else
            width = 4'd8;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        bif_next       = bif_reg;
        shift_next     = shift_reg;
        entries_next   = entries_reg;
        entry_cnt_next = entry_cnt_reg;
        payload_next   = payload_reg;
        err_next       = err_reg;
        kind_next      = eff_kind;
        in_msg_next    = 1'b1;
        do_fail        = 1'b0;
        fail_code      = crd_pkg::ST_OK;
        entry_end      = 1'b0;
        v              = shift_cat;
        rec            = '0;

        if (item.has_byte)
        begin
            if (phase_reg == PH_ERROR)
            begin
                // swallow bytes until the end mark
            end
            else if (phase_reg == PH_DONE || phase_reg > PH_ERROR)
            begin
                do_fail   = 1'b1;
                fail_code = crd_pkg::ST_TRAILING;
            end
            else if (phase_reg == PH_E_KEY || phase_reg == PH_E_VAL)
            begin
                rec.has_res              = 1'b1;
                rec.res.out_kind         = (phase_reg == PH_E_KEY) ? crd_pkg::KIND_KEY
                                                                   : crd_pkg::KIND_VALUE;
                rec.res.field_value      = {56'd0, item.data_byte};
                rec.res.entry_number     = entry_cnt_reg;
                payload_next             = payload_reg - LENGTH_BITS'(1);
                if (payload_reg == {{(LENGTH_BITS-1){1'b0}}, 1'b1})
                begin
                    if (phase_reg == PH_E_KEY)
                        phase_next = PH_E_VLEN;
                    else
                        entry_end = 1'b1;
                end
            end
            else if ({1'b0, bif_reg} + 4'd1 < width)
            begin
                shift_next = shift_cat;
                bif_next   = bif_reg + 3'd1;
            end
            else
            begin
                bif_next   = 3'd0;
                shift_next = 64'd0;
                if (phase_reg < PH_E_TERM)
                begin
                    if ((eff_kind == crd_pkg::MSG_VOTE_REPLY
                         || eff_kind == crd_pkg::MSG_APPEND_REPLY) && phase_reg == 4'd1)
                        v = {63'd0, shift_cat != 64'd0};
                    rec.has_res             = 1'b1;
                    rec.res.out_kind        = crd_pkg::KIND_HEADER;
                    rec.res.field_index     = phase_reg[2:0];
                    rec.res.field_value     = v;
                    if (phase_reg[2:0] + 3'd1 < crd_pkg::hdr_count(eff_kind))
                        phase_next = phase_reg + 4'd1;
                    else if (eff_kind == crd_pkg::MSG_APPEND_REQ)
                    begin
                        entries_next   = v[31:0];
                        entry_cnt_next = 32'd0;
                        phase_next     = (v[31:0] == 32'd0) ? PH_DONE : PH_E_TERM;
                    end
                    else
                        phase_next = PH_DONE;
                end
                else if (phase_reg == PH_E_TERM || phase_reg == PH_E_INDEX)
                begin
                    rec.has_res             = 1'b1;
                    rec.res.out_kind        = crd_pkg::KIND_ENTRY;
                    rec.res.field_index     = (phase_reg == PH_E_TERM) ? crd_pkg::EF_TERM
                                                                       : crd_pkg::EF_INDEX;
                    rec.res.field_value     = v;
                    rec.res.entry_number    = entry_cnt_reg;
                    phase_next              = phase_reg + 4'd1;
                end
                else if (phase_reg == PH_E_OP)
                begin
                    if (item.data_byte != op_set_reg && item.data_byte != op_del_reg)
                    begin
                        do_fail   = 1'b1;
                        fail_code = crd_pkg::ST_BAD_OP;
                    end
                    else
                    begin
                        rec.has_res          = 1'b1;
                        rec.res.out_kind     = crd_pkg::KIND_ENTRY;
                        rec.res.field_index  = crd_pkg::EF_OP;
                        rec.res.field_value  = {56'd0, item.data_byte};
                        rec.res.entry_number = entry_cnt_reg;
                        phase_next           = PH_E_KLEN;
                    end
                end
                else
                begin
                    // key or value length
                    if ((v[31:0] >> LENGTH_BITS) != 32'd0)
                    begin
                        do_fail   = 1'b1;
                        fail_code = crd_pkg::ST_TRUNCATED;
                    end
                    else
                    begin
                        rec.has_res          = 1'b1;
                        rec.res.out_kind     = crd_pkg::KIND_ENTRY;
                        rec.res.field_index  = (phase_reg == PH_E_KLEN) ? crd_pkg::EF_KLEN
                                                                        : crd_pkg::EF_VLEN;
                        rec.res.field_value  = v;
                        rec.res.entry_number = entry_cnt_reg;
                        payload_next         = v[LENGTH_BITS-1:0];
                        if (phase_reg == PH_E_KLEN)
                            phase_next = (v[31:0] == 32'd0) ? PH_E_VLEN : PH_E_KEY;
                        else if (v[31:0] != 32'd0)
                            phase_next = PH_E_VAL;
                        else
                            entry_end = 1'b1;
                    end
                end
            end
        end

        if (entry_end)
        begin
            entry_cnt_next = entry_cnt_reg + 32'd1;
            entries_next   = entries_reg - 32'd1;
            phase_next     = (entries_reg == 32'd1) ? PH_DONE : PH_E_TERM;
        end

        if (do_fail)
        begin
            if (err_reg == crd_pkg::ST_OK)
                err_next = fail_code;
            phase_next = PH_ERROR;
        end

        if (item.end_of_message)
        begin
            rec.has_status = 1'b1;
            if (err_next != crd_pkg::ST_OK)
                rec.status = err_next;
            else if (phase_next == PH_DONE)
                rec.status = crd_pkg::ST_OK;
            else
                rec.status = crd_pkg::ST_TRUNCATED;
            phase_next     = PH_HDR0;
            bif_next       = 3'd0;
            shift_next     = 64'd0;
            entries_next   = 32'd0;
            entry_cnt_next = 32'd0;
            payload_next   = '0;
            err_next       = crd_pkg::ST_OK;
            kind_next      = crd_pkg::MSG_VOTE_REQ;
            in_msg_next    = 1'b0;
        end
    end

    assign push = active && (rec.has_res || rec.has_status);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_set_reg <= 8'd0;
            op_del_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == crd_pkg::REG_OP_SET)
                op_set_reg <= cfg_data;
            else if (cfg_index == crd_pkg::REG_OP_DELETE)
                op_del_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            bif_reg       <= 3'd0;
            shift_reg     <= 64'd0;
            entries_reg   <= 32'd0;
            entry_cnt_reg <= 32'd0;
            payload_reg   <= '0;
            err_reg       <= crd_pkg::ST_OK;
            kind_reg      <= crd_pkg::MSG_VOTE_REQ;
            in_msg_reg    <= 1'b0;
        end
        else if (active)
        begin
            phase_reg     <= phase_next;
            bif_reg       <= bif_next;
            shift_reg     <= shift_next;
            entries_reg   <= entries_next;
            entry_cnt_reg <= entry_cnt_next;
            payload_reg   <= payload_next;
            err_reg       <= err_next;
            kind_reg      <= kind_next;
            in_msg_reg    <= in_msg_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/crd_queue.sv =====
// short record queue between the parser and the result sequencer
`timescale 1ns / 1ps
`default_nettype none
module crd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire crd_pkg::rec_t wr_rec,
    input  wire logic          pop,
    output crd_pkg::rec_t      head,
    output logic               empty,
    output logic               full
);

    localparam int PTR_W = $clog2(crd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(crd_pkg::QUEUE_DEPTH + 1);

    crd_pkg::rec_t    mem [crd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == CNT_W'(0));
    assign full    = (count_reg == CNT_W'(crd_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(crd_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(crd_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/crd_back.sv =====
// result sequencer: splits each record into beats and holds the output register
`timescale 1ns / 1ps
`default_nettype none
module crd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire crd_pkg::rec_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               result_valid,
    input  wire logic          result_stall,
    output crd_pkg::result_t   result
);

    crd_pkg::result_t out_reg, out_next;
    logic             valid_reg, valid_next;
    logic             res_done_reg, res_done_next;
    logic             slot_free;

    assign slot_free = !valid_reg || !result_stall;

    always_comb
    begin
        out_next      = out_reg;
        valid_next    = valid_reg && result_stall;
        res_done_next = res_done_reg;
        pop           = 1'b0;
        if (slot_free && !empty)
        begin
            valid_next = 1'b1;
            if (head.has_res && !res_done_reg)
            begin
                out_next = head.res;
                if (head.has_status)
                    res_done_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else
            begin
                // closing status beat
                out_next              = '0;
                out_next.out_kind     = crd_pkg::KIND_STATUS;
                out_next.status       = head.status;
                out_next.last         = 1'b1;
                res_done_next         = 1'b0;
                pop                   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            res_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            res_done_reg <= res_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ===== rtl/consensus_rpc_deframer.sv =====
// top level of the consensus rpc deframer: parser, record queue and result sequencer
// throughput: one input beat per cycle unless the queue is full; one result beat
// per cycle unless stalled; a message-ending field or byte item adds a status beat
// a four-record queue decouples the parser from the output register
// reset: asynchronous, clears all parse state and sets the op codes to 0 and 1
`timescale 1ns / 1ps
`default_nettype none
module consensus_rpc_deframer #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire crd_pkg::item_t                item,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output crd_pkg::result_t                   result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [crd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data
);

    logic          take;
    logic          push;
    crd_pkg::rec_t rec;
    crd_pkg::rec_t head;
    logic          q_empty;
    logic          q_full;
    logic          pop;

    assign item_stall = q_full;
    assign take       = item_valid && !q_full;
    assign cfg_ready  = 1'b1;

    crd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .rec       (rec)
    );

    crd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (rec),
        .pop    (pop),
        .head   (head),
        .empty  (q_empty),
        .full   (q_full)
    );

    crd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

// ===== tb/deframer_checker.sv =====
// checker for the consensus rpc deframer: tracks its parse state and compares every result beat
`timescale 1ns / 1ps
module deframer_checker #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  crd_pkg::item_t                item,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  crd_pkg::result_t              result,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [crd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            results_seen
);

    localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS) - 64'd1;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_ENTRY_TERM,
        PH_ENTRY_INDEX,
        PH_ENTRY_OP,
        PH_KEY_LEN,
        PH_KEY,
        PH_VALUE_LEN,
        PH_VALUE,
        PH_COMPLETE,
        PH_FAILED
    } parse_phase_t;

    logic [7:0]       set_code;
    logic [7:0]       delete_code;
    parse_phase_t     phase;
    logic [2:0]       hdr_field;
    int unsigned      byte_cnt;
    logic [63:0]      shift_reg;
    logic [31:0]      entries_left;
    logic [31:0]      entry_no;
    logic [31:0]      payload_left;
    logic [1:0]       latched;
    logic [1:0]       msg_kind;
    bit               in_msg;
    crd_pkg::result_t due_results[$];
    int               mismatches;
    int               beats_seen;

    function automatic int unsigned header_bytes(input logic [1:0] kind, input logic [2:0] fld);
        if (fld == 3'd0)
            return 8;
        if (kind == crd_pkg::MSG_VOTE_REPLY || kind == crd_pkg::MSG_APPEND_REPLY)
            return 1;
        if (fld == 3'd1 || fld == 3'd5)
            return 4;
        return 8;
    endfunction

    function automatic logic [2:0] header_fields(input logic [1:0] kind);
        if (kind == crd_pkg::MSG_VOTE_REQ)
            return 3'd4;
        if (kind == crd_pkg::MSG_APPEND_REQ)
            return 3'd6;
        return 3'd2;
    endfunction

    task automatic queue_result(input crd_pkg::result_t r);
        due_results.insert(due_results.size(), r);
    endtask

    task automatic restart_message();
        phase = PH_HEADER;
        hdr_field = 3'd0;
        byte_cnt = 0;
        shift_reg = '0;
        entries_left = '0;
        entry_no = '0;
        payload_left = '0;
        latched = crd_pkg::ST_OK;
        msg_kind = crd_pkg::MSG_VOTE_REQ;
        in_msg = 1'b0;
    endtask

    task automatic latch_error(input logic [1:0] code);
        if (latched == crd_pkg::ST_OK)
            latched = code;
        phase = PH_FAILED;
    endtask

    task automatic close_entry();
        entry_no = entry_no + 32'd1;
        entries_left = entries_left - 32'd1;
        phase = (entries_left == 0) ? PH_COMPLETE : PH_ENTRY_TERM;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        int unsigned      width;
        logic [63:0]      v;
        crd_pkg::result_t r;
        r = '0;
        if (phase == PH_FAILED)
            return;
        if (phase == PH_COMPLETE)
        begin
            latch_error(crd_pkg::ST_TRAILING);
            return;
        end
        if (phase == PH_KEY || phase == PH_VALUE)
        begin
            r.out_kind = (phase == PH_KEY) ? crd_pkg::KIND_KEY : crd_pkg::KIND_VALUE;
            r.field_value = {56'd0, b};
            r.entry_number = entry_no;
            queue_result(r);
            payload_left = payload_left - 32'd1;
            if (payload_left == 0)
            begin
                if (phase == PH_KEY)
                    phase = PH_VALUE_LEN;
                else
                    close_entry();
            end
            return;
        end

        case (phase)
            PH_HEADER:                width = header_bytes(msg_kind, hdr_field);
            PH_ENTRY_OP:              width = 1;
            PH_KEY_LEN, PH_VALUE_LEN: width = 4;
            default:                  width = 8;
        endcase
        shift_reg = {shift_reg[55:0], b};
        if (byte_cnt + 1 < width)
        begin
            byte_cnt = byte_cnt + 1;
            return;
        end
        v = shift_reg;
        byte_cnt = 0;
        shift_reg = '0;

        if (phase == PH_HEADER)
        begin
            // reply flags are normalised to 0/1
            if ((msg_kind == crd_pkg::MSG_VOTE_REPLY || msg_kind == crd_pkg::MSG_APPEND_REPLY)
                && hdr_field == 3'd1)
                v = (v != 0) ? 64'd1 : 64'd0;
            r.out_kind = crd_pkg::KIND_HEADER;
            r.field_index = hdr_field;
            r.field_value = v;
            queue_result(r);
            if (hdr_field + 3'd1 < header_fields(msg_kind))
                hdr_field = hdr_field + 3'd1;
            else if (msg_kind == crd_pkg::MSG_APPEND_REQ)
            begin
                entries_left = v[31:0];
                entry_no = '0;
                phase = (entries_left == 0) ? PH_COMPLETE : PH_ENTRY_TERM;
            end
            else
                phase = PH_COMPLETE;
            return;
        end

        r.out_kind = crd_pkg::KIND_ENTRY;
        r.entry_number = entry_no;
        r.field_value = v;
        case (phase)
            PH_ENTRY_TERM:
            begin
                r.field_index = crd_pkg::EF_TERM;
                queue_result(r);
                phase = PH_ENTRY_INDEX;
            end
            PH_ENTRY_INDEX:
            begin
                r.field_index = crd_pkg::EF_INDEX;
                queue_result(r);
                phase = PH_ENTRY_OP;
            end
            PH_ENTRY_OP:
            begin
                if (b != set_code && b != delete_code)
                    latch_error(crd_pkg::ST_BAD_OP);
                else
                begin
                    r.field_index = crd_pkg::EF_OP;
                    queue_result(r);
                    phase = PH_KEY_LEN;
                end
            end
            default:
            begin
                if (v > LEN_MAX)
                    latch_error(crd_pkg::ST_TRUNCATED);
                else
                begin
                    r.field_index = (phase == PH_KEY_LEN) ? crd_pkg::EF_KLEN : crd_pkg::EF_VLEN;
                    queue_result(r);
                    payload_left = v[31:0];
                    if (phase == PH_KEY_LEN)
                        phase = (payload_left == 0) ? PH_VALUE_LEN : PH_KEY;
                    else if (payload_left != 0)
                        phase = PH_VALUE;
                    else
                        close_entry();
                end
            end
        endcase
    endtask

    task automatic deframe_item(input crd_pkg::item_t it);
        crd_pkg::result_t r;
        r = '0;
        if (!it.has_byte && !it.end_of_message)
            return;
        if (!in_msg)
        begin
            msg_kind = it.req_type;
            in_msg = 1'b1;
        end
        if (it.has_byte)
            deframe_byte(it.data_byte);
        if (it.end_of_message)
        begin
            r.out_kind = crd_pkg::KIND_STATUS;
            r.last = 1'b1;
            if (latched != crd_pkg::ST_OK)
                r.status = latched;
            else if (phase == PH_COMPLETE)
                r.status = crd_pkg::ST_OK;
            else
                r.status = crd_pkg::ST_TRUNCATED;
            queue_result(r);
            restart_message();
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endtask

    task automatic check_beat(input crd_pkg::result_t got);
        crd_pkg::result_t want;
        beats_seen++;
        if (due_results.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result beat, expected none, got %h", $time, got);
            return;
        end
        want = due_results.pop_front();
        if (got.out_kind !== want.out_kind)
            flag_mismatch("out_kind", 64'(want.out_kind), 64'(got.out_kind));
        if (got.field_index !== want.field_index)
            flag_mismatch("field_index", 64'(want.field_index), 64'(got.field_index));
        if (got.field_value !== want.field_value)
            flag_mismatch("field_value", want.field_value, got.field_value);
        if (got.entry_number !== want.entry_number)
            flag_mismatch("entry_number", 64'(want.entry_number), 64'(got.entry_number));
        if (got.status !== want.status)
            flag_mismatch("status", 64'(want.status), 64'(got.status));
        if (got.last !== want.last)
            flag_mismatch("last", 64'(want.last), 64'(got.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_code = 8'd0;
            delete_code = 8'd1;
            restart_message();
            due_results.delete();
            mismatches = 0;
            beats_seen = 0;
            fail_count <= 0;
            pending <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_beat(result);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    crd_pkg::REG_OP_SET:    set_code = cfg_data;
                    crd_pkg::REG_OP_DELETE: delete_code = cfg_data;
                    default:                ;
                endcase
            end
            if (item_valid && !item_stall)
                deframe_item(item);
            fail_count <= mismatches;
            pending <= due_results.size();
            results_seen <= beats_seen;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// top of the deframer testbench: clock, reset, stimulus, receiver idling and the verdict
`timescale 1ns / 1ps
module testbench;

    localparam int LENGTH_BITS     = 32;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 200;
    localparam int ITEMS_PER_PHASE = 330;
    localparam int DRAIN_CYCLES    = 8;

    logic                          clk;
    logic                          rst_n;
    logic                          item_valid;
    logic                          item_stall;
    crd_pkg::item_t                item;
    logic                          result_valid;
    logic                          result_stall;
    crd_pkg::result_t              result;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [crd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                    cfg_data;

    int         fail_count;
    int         pending;
    int         results_seen;
    logic [7:0] op_set;
    logic [7:0] op_del;
    logic [7:0] wire_bytes[$];
    int         gap_pct;
    int         stall_pct;
    bit         quiet;
    bit         hold_off_go;
    int         items_sent;
    int         messages_sent;
    int         cycle_count;

    consensus_rpc_deframer #(.LENGTH_BITS(LENGTH_BITS)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    deframer_checker #(.LENGTH_BITS(LENGTH_BITS)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [1:0] pick_kind();
        if ($urandom_range(0, 9) < 4)
            return crd_pkg::MSG_APPEND_REQ;
        return 2'($urandom);
    endfunction

    task automatic offer_item(input logic [7:0] b, input logic has, input logic [1:0] kind,
                              input logic eom);
        crd_pkg::item_t it;
        it.data_byte = b;
        it.has_byte = has;
        it.req_type = kind;
        it.end_of_message = eom;
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        if (has || eom)
            items_sent++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_op_codes(input logic [7:0] set_val, input logic [7:0] del_val);
        cfg_valid <= 1'b1;
        cfg_index <= crd_pkg::REG_OP_SET;
        cfg_data <= set_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= crd_pkg::REG_OP_DELETE;
        cfg_data <= del_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        op_set = set_val;
        op_del = del_val;
    endtask

    task automatic add_byte(input logic [7:0] b);
        wire_bytes.insert(wire_bytes.size(), b);
    endtask

    task automatic put_field(input logic [63:0] v, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            add_byte(v[i*8 +: 8]);
    endtask

    task automatic compose_message(input logic [1:0] kind);
        int         n_entries;
        int         klen;
        int         vlen;
        logic [7:0] op;
        wire_bytes.delete();
        put_field(pick_value(), 8);
        case (kind)
            crd_pkg::MSG_VOTE_REQ:
            begin
                put_field(pick_value(), 4);
                put_field(pick_value(), 8);
                put_field(pick_value(), 8);
            end
            crd_pkg::MSG_APPEND_REQ:
            begin
                put_field(pick_value(), 4);
                put_field(pick_value(), 8);
                put_field(pick_value(), 8);
                put_field(pick_value(), 8);
                if ($urandom_range(0, 19) == 0)
                begin
                    // huge entry count and key length, cut short
                    put_field(64'hFFFF_FFFF, 4);
                    put_field(pick_value(), 8);
                    put_field(pick_value(), 8);
                    add_byte(op_set);
                    put_field(64'hFFFF_FFFF, 4);
                    repeat (3) add_byte(pick_byte());
                end
                else
                begin
                    n_entries = $urandom_range(0, 3);
                    put_field(64'(n_entries), 4);
                    repeat (n_entries)
                    begin
                        put_field(pick_value(), 8);
                        put_field(pick_value(), 8);
                        case ($urandom_range(0, 9))
                            0:          op = pick_byte();
                            1, 2, 3, 4: op = op_set;
                            default:    op = op_del;
                        endcase
                        add_byte(op);
                        klen = $urandom_range(0, 5);
                        put_field(64'(klen), 4);
                        repeat (klen) add_byte(pick_byte());
                        vlen = $urandom_range(0, 6);
                        put_field(64'(vlen), 4);
                        repeat (vlen) add_byte(pick_byte());
                    end
                end
            end
            default:
                add_byte(($urandom_range(0, 2) == 0) ? 8'h00 : pick_byte());
        endcase
    endtask

    task automatic send_message(input logic [1:0] kind);
        int cut;
        bit bare;
        compose_message(kind);
        case ($urandom_range(0, 9))
            0:
            begin
                cut = $urandom_range(0, wire_bytes.size() - 1);
                while (wire_bytes.size() > cut)
                    wire_bytes.delete(wire_bytes.size() - 1);
            end
            1:       repeat ($urandom_range(1, 3)) add_byte(pick_byte());
            default: ;
        endcase
        bare = ($urandom_range(0, 1) == 1) || (wire_bytes.size() == 0);
        foreach (wire_bytes[i])
        begin
            if ($urandom_range(0, 24) == 0)
                offer_item(8'($urandom), 1'b0, 2'($urandom), 1'b0);
            offer_item(wire_bytes[i], 1'b1, (i == 0) ? kind : 2'($urandom),
                       !bare && (i == wire_bytes.size() - 1));
        end
        if (bare)
            offer_item(8'($urandom), 1'b0, (wire_bytes.size() == 0) ? kind : 2'($urandom), 1'b1);
        messages_sent++;
    endtask

    initial
    begin : receiver
        int burst;
        bit held;
        burst = 0;
        held = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_go && !held)
            begin
                // long hold-off so that the block backs up into its input
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (burst > 0)
            begin
                burst--;
                result_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                burst = $urandom_range(1, 8) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        int phase_end;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= crd_pkg::REG_OP_SET;
        cfg_data <= 8'd0;
        op_set = 8'd0;
        op_del = 8'd1;
        gap_pct = 25;
        stall_pct = 25;
        quiet = 1'b0;
        hold_off_go = 1'b0;
        items_sent = 0;
        messages_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bare end mark on an empty message, then an item that carries nothing
        offer_item(8'h00, 1'b0, crd_pkg::MSG_APPEND_REQ, 1'b1);
        offer_item(8'h3C, 1'b0, crd_pkg::MSG_VOTE_REQ, 1'b0);
        // vote reply, all-ones term, refused, end mark on the last byte
        for (int i = 0; i < 8; i++)
            offer_item(8'hFF, 1'b1, (i == 0) ? crd_pkg::MSG_VOTE_REPLY : 2'($urandom), 1'b0);
        offer_item(8'h00, 1'b1, crd_pkg::MSG_APPEND_REQ, 1'b1);
        // append reply with a non-zero success byte and one trailing byte
        for (int i = 0; i < 8; i++)
            offer_item(8'h00, 1'b1, (i == 0) ? crd_pkg::MSG_APPEND_REPLY : 2'($urandom), 1'b0);
        offer_item(8'h80, 1'b1, crd_pkg::MSG_VOTE_REQ, 1'b0);
        offer_item(8'hAA, 1'b1, crd_pkg::MSG_APPEND_REQ, 1'b1);
        // vote request cut off after three bytes
        offer_item(8'h01, 1'b1, crd_pkg::MSG_VOTE_REQ, 1'b0);
        offer_item(8'h7F, 1'b1, crd_pkg::MSG_APPEND_REPLY, 1'b0);
        offer_item(8'hFE, 1'b1, crd_pkg::MSG_VOTE_REPLY, 1'b0);
        offer_item(8'h55, 1'b0, crd_pkg::MSG_APPEND_REQ, 1'b1);

        for (int p = 0; p < 5; p++)
        begin
            drain();
            case (p)
                1:
                begin
                    load_op_codes(8'hFF, 8'h00);
                    gap_pct = 10;
                    stall_pct = 50;
                end
                2:
                begin
                    load_op_codes(8'h5A, 8'h5A);
                    gap_pct = 0;
                    stall_pct = 20;
                    hold_off_go = 1'b1;
                end
                3:
                begin
                    load_op_codes(8'h00, 8'hFF);
                    gap_pct = 50;
                    stall_pct = 0;
                end
                4:
                begin
                    load_op_codes(8'($urandom), 8'($urandom));
                    quiet = 1'b1;
                end
                default: ;
            endcase
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end)
                send_message(pick_kind());
        end
        drain();

        $display("covered %0d messages of all kinds in %0d items, %0d result beats checked",
                 messages_sent, items_sent, results_seen);
        $display("five op code settings, truncation, trailing bytes, bad ops and a long hold-off");
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
